/* rtl/tps_pkg.sv */
// Shared types and constants for the twin prime search block.
package tps_pkg;

   localparam int unsigned NUMBER_BITS = 16;

   localparam logic OP_TEST = 1'b0;
   localparam logic OP_TWIN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_STEP,
      ST_HI,
      ST_LO,
      ST_DONE
   } top_state_type;

   typedef enum logic [1:0] {
      PT_IDLE,
      PT_CHECK,
      PT_DIV
   } pt_state_type;

   typedef struct packed {
      logic done;
      logic prime;
   } pt_status_type;

endpackage

/* rtl/tps_req_if.sv */
// Request channel: opcode and number with valid/ready handshake.
interface tps_req_if
   import tps_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   opcode;
   logic [NUMBER_BITS-1:0] number;

   modport source (output valid, output opcode, output number, input ready);
   modport sink (input valid, input opcode, input number, output ready);
endinterface

/* rtl/tps_rsp_if.sv */
// Response channel: twin prime result and flags with valid/ready handshake.
interface tps_rsp_if
   import tps_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [NUMBER_BITS-1:0] twin_upper;
   logic                   prime_flag;
   logic                   found_flag;
   logic                   input_error;

   modport source (output valid, output twin_upper, output prime_flag,
                   output found_flag, output input_error, input ready);
   modport sink (input valid, input twin_upper, input prime_flag,
                 input found_flag, input input_error, output ready);
endinterface

/* rtl/twin_prime_search.sv */
// Twin prime search top level: request sequencing and response register.
// Each request is handled alone; req.ready is high only while the block is
// idle. A primality test of n tries up to floor(sqrt(n)) - 1 trial
// divisors, each worked through the single bit-serial remainder unit. A twin
// search repeats that test for each candidate above n (and for candidate - 2
// when the candidate is prime), so its time grows with the gap to the next
// twin pair. The result sits in an output register, so a new request can be
// taken while the previous response waits.
module twin_prime_search
   import tps_pkg::*;
#(
   parameter int unsigned VALUE_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   tps_req_if.sink   req_bus,
   tps_rsp_if.source rsp_bus
);

   localparam logic [VALUE_BITS-1:0] VAL_MAX = '1;

   top_state_type         state_ff, state_in;
   logic [VALUE_BITS-1:0] v_ff, v_in;
   logic [VALUE_BITS-1:0] upper_ff, upper_in;
   logic                  pflag_ff, pflag_in;
   logic                  found_ff, found_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_upper_ff, rsp_upper_in;
   logic                  rsp_pflag_ff, rsp_pflag_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic                  rsp_err_ff, rsp_err_in;
   logic                  pt_start;
   logic [VALUE_BITS-1:0] pt_value;
   pt_status_type         pt_status;
   logic [VALUE_BITS-1:0] req_value;

   assign req_value = VALUE_BITS'(req_bus.number);

   tps_prime_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) u_prime (
      .clock  (clock),
      .reset  (reset),
      .start  (pt_start),
      .value  (pt_value),
      .status (pt_status)
   );

   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      upper_in     = upper_ff;
      pflag_in     = pflag_ff;
      found_in     = found_ff;
      err_in       = err_ff;
      pt_start     = 1'b0;
      pt_value     = req_value;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_upper_in = rsp_upper_ff;
      rsp_pflag_in = rsp_pflag_ff;
      rsp_found_in = rsp_found_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               upper_in = '0;
               pflag_in = 1'b0;
               found_in = 1'b0;
               err_in   = 1'b0;
               v_in     = req_value;
               if (req_bus.opcode == OP_TEST) begin
                  pt_start = 1'b1;
                  state_in = ST_PRIME;
               end else if (req_value < VALUE_BITS'(2)) begin
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_PRIME: begin
            if (pt_status.done) begin
               pflag_in = pt_status.prime;
               state_in = ST_DONE;
            end
         end
         ST_STEP: begin
            if (v_ff == VAL_MAX) begin
               state_in = ST_DONE;
            end else begin
               v_in     = v_ff + 1'b1;
               pt_value = v_ff + 1'b1;
               pt_start = 1'b1;
               state_in = ST_HI;
            end
         end
         ST_HI: begin
            pt_value = v_ff - VALUE_BITS'(2);
            if (pt_status.done) begin
               if (pt_status.prime) begin
                  pt_start = 1'b1;
                  state_in = ST_LO;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_LO: begin
            if (pt_status.done) begin
               if (pt_status.prime) begin
                  upper_in = v_ff;
                  found_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_upper_in = upper_ff;
               rsp_pflag_in = pflag_ff;
               rsp_found_in = found_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff         <= v_in;
      upper_ff     <= upper_in;
      pflag_ff     <= pflag_in;
      found_ff     <= found_in;
      err_ff       <= err_in;
      rsp_upper_ff <= rsp_upper_in;
      rsp_pflag_ff <= rsp_pflag_in;
      rsp_found_ff <= rsp_found_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.twin_upper  = NUMBER_BITS'(rsp_upper_ff);
   assign rsp_bus.prime_flag  = rsp_pflag_ff;
   assign rsp_bus.found_flag  = rsp_found_ff;
   assign rsp_bus.input_error = rsp_err_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request taken while a transaction is in progress");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.found_flag && rsp_bus.prime_flag))
      else $error("prime and found flags both set");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.input_error |->
         !rsp_bus.found_flag && (rsp_bus.twin_upper == '0))
      else $error("input error response carries a result");

   a_found_odd: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.found_flag |-> rsp_bus.twin_upper[0])
      else $error("twin result is even");

endmodule

/* rtl/tps_rem_unit.sv */
// Restoring remainder unit, one quotient bit per cycle.
module tps_rem_unit #(
   parameter int unsigned VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [VALUE_BITS-1:0] divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] remainder
);

   localparam int unsigned CW = $clog2(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] dvd_ff, dvd_in;
   logic [VALUE_BITS-1:0] dvs_ff, dvs_in;
   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;

   assign trial = {rem_ff, dvd_ff[VALUE_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(VALUE_BITS - 1);
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = diff[VALUE_BITS] ? trial[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/tps_prime_unit.sv */
// Trial division primality tester built around a single remainder unit.
module tps_prime_unit
   import tps_pkg::*;
#(
   parameter int unsigned VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] value,
   output pt_status_type         status
);

   pt_state_type          state_ff, state_in;
   logic                  done_ff, done_in;
   logic                  prime_ff, prime_in;
   logic [VALUE_BITS-1:0] n_ff, n_in;
   logic [VALUE_BITS-1:0] d_ff, d_in;
   logic [VALUE_BITS:0]   sq_ff, sq_in;
   logic                  rem_start;
   logic                  rem_done;
   logic [VALUE_BITS-1:0] rem_value;

   tps_rem_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      prime_in  = prime_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      rem_start = 1'b0;
      case (state_ff)
         PT_IDLE: begin
            if (start) begin
               n_in = value;
               if (value < VALUE_BITS'(2)) begin
                  done_in  = 1'b1;
                  prime_in = 1'b0;
               end else begin
                  d_in     = VALUE_BITS'(2);
                  sq_in    = (VALUE_BITS+1)'(4);
                  state_in = PT_CHECK;
               end
            end
         end
         PT_CHECK: begin
            // stop once the divisor squared passes the number
            if (sq_ff > {1'b0, n_ff}) begin
               done_in  = 1'b1;
               prime_in = 1'b1;
               state_in = PT_IDLE;
            end else begin
               rem_start = 1'b1;
               state_in  = PT_DIV;
            end
         end
         PT_DIV: begin
            if (rem_done) begin
               if (rem_value == '0) begin
                  done_in  = 1'b1;
                  prime_in = 1'b0;
                  state_in = PT_IDLE;
               end else begin
                  d_in     = d_ff + 1'b1;
                  sq_in    = sq_ff + {d_ff, 1'b1};
                  state_in = PT_CHECK;
               end
            end
         end
         default: state_in = PT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PT_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prime_ff <= prime_in;
      n_ff     <= n_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
   end

   assign status.done  = done_ff;
   assign status.prime = prime_ff;

endmodule

/* test/tps_scoreboard.sv */
// Scoreboard for the twin prime search block: predicts each response and compares it.
module tps_scoreboard
   import tps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tps_req_if          req_bus,
   tps_rsp_if          rsp_bus,
   output int          fails,
   output int unsigned pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TOP_VALUE = (1 << NUMBER_BITS) - 1;

   typedef struct packed {
      logic [NUMBER_BITS-1:0] twin_upper;
      logic                   prime_flag;
      logic                   found_flag;
      logic                   input_error;
   } twin_answer_type;

   twin_answer_type answers_due[$];

   function automatic bit prime_by_trial(int unsigned n);
      if (n < 2) return 1'b0;
      for (int unsigned d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic twin_answer_type answer_for(logic op, logic [NUMBER_BITS-1:0] num);
      twin_answer_type a;
      int unsigned     v;
      a = '0;
      if (op == OP_TEST) begin
         a.prime_flag = prime_by_trial(32'(num));
      end else if (num < 2) begin
         a.input_error = 1'b1;
      end else begin
         v = 32'(num);
         while (v < TOP_VALUE) begin
            v++;
            if (prime_by_trial(v) && prime_by_trial(v - 2)) begin
               a.twin_upper = v[NUMBER_BITS-1:0];
               a.found_flag = 1'b1;
               break;
            end
         end
      end
      return a;
   endfunction

   always @(posedge clock) begin
      twin_answer_type want;
      twin_answer_type got;
      if (reset) begin
         answers_due.delete();
      end else begin
         if (req_bus.valid && req_bus.ready)
            answers_due.push_back(answer_for(req_bus.opcode, req_bus.number));
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.twin_upper, rsp_bus.prime_flag, rsp_bus.found_flag,
                    rsp_bus.input_error};
            if (answers_due.size() == 0) begin
               $display("%0t: response with none outstanding: upper %0d p %b f %b e %b",
                        $time, got.twin_upper, got.prime_flag, got.found_flag,
                        got.input_error);
               fails++;
            end else begin
               want = answers_due.pop_front();
               if (got !== want) begin
                  $display("%0t: expected upper %0d p %b f %b e %b, got upper %0d p %b f %b e %b",
                           $time, want.twin_upper, want.prime_flag, want.found_flag,
                           want.input_error, got.twin_upper, got.prime_flag,
                           got.found_flag, got.input_error);
                  fails++;
               end
            end
         end
      end
      pending <= answers_due.size();
   end

endmodule

/* test/tb_twin_prime_search.sv */
// Testbench top for the twin prime search block: clock, reset, stimulus and verdict.
module tb_twin_prime_search;
   import tps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 80;
   localparam int HOLD_CYCLES  = 3000;

   logic        clock;
   logic        reset;
   int          fails;
   int unsigned pending;
   bit          hold_rsp;
   bit          quiet;

   tps_req_if req_bus ();
   tps_rsp_if rsp_bus ();

   twin_prime_search u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tps_scoreboard u_scoreboard (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .fails   (fails),
      .pending (pending)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #400_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // one transaction, optionally preceded by an idle burst
   task automatic send_item(input logic op, input logic [NUMBER_BITS-1:0] num);
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.number <= num;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // receiver side: random back-pressure, plus one long hold on request
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   initial begin
      logic                   op;
      logic [NUMBER_BITS-1:0] num;
      hold_rsp = 1'b0;
      quiet    = 1'b0;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.opcode <= OP_TEST;
      req_bus.number <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // primality corners
      send_item(OP_TEST, 16'd0);
      send_item(OP_TEST, 16'd1);
      send_item(OP_TEST, 16'd2);
      send_item(OP_TEST, 16'd3);
      send_item(OP_TEST, 16'd4);
      send_item(OP_TEST, 16'd97);
      send_item(OP_TEST, 16'd32768);
      send_item(OP_TEST, 16'd65519);
      send_item(OP_TEST, 16'd65521);
      send_item(OP_TEST, 16'hFFFF);
      // twin search: bad start, smallest pairs, top of range
      send_item(OP_TWIN, 16'd0);
      send_item(OP_TWIN, 16'd1);
      send_item(OP_TWIN, 16'd2);
      send_item(OP_TWIN, 16'd3);
      send_item(OP_TWIN, 16'd4);
      send_item(OP_TWIN, 16'd5);
      send_item(OP_TWIN, 16'd65518);
      send_item(OP_TWIN, 16'd65520);
      send_item(OP_TWIN, 16'd65521);
      send_item(OP_TWIN, 16'd65534);
      send_item(OP_TWIN, 16'hFFFF);
      drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= RANDOM_ITEMS - 20);
         if (i == 30) begin
            // fill the output register and stall the request side
            hold_rsp = 1'b1;
            repeat (6) begin
               if ($urandom_range(0, 1))
                  send_item(OP_TWIN, NUMBER_BITS'($urandom_range(0, 1)));
               else
                  send_item(OP_TEST, NUMBER_BITS'($urandom_range(0, 100)));
            end
         end
         if (i == 60) drain();
         op = 1'($urandom_range(0, 1));
         if (op == OP_TEST)
            num = ($urandom_range(0, 3) == 0) ? NUMBER_BITS'($urandom_range(0, 65535))
                                              : NUMBER_BITS'($urandom_range(0, 4095));
         else if ($urandom_range(0, 15) == 0)
            num = NUMBER_BITS'($urandom_range(0, 65535));
         else if ($urandom_range(0, 15) == 0)
            num = NUMBER_BITS'($urandom_range(0, 1));
         else
            num = NUMBER_BITS'($urandom_range(0, 2047));
         send_item(op, num);
      end

      drain();
      repeat (50) @(posedge clock);
      if (fails == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
